// ----- hdl/ptot_pkg.sv -----
// Shared types and constants for the pose tool offset transform.
`timescale 1ns / 1ps
package ptot_pkg;

   // Number formats
   localparam int FRAC_BITS  = 16;
   localparam int PHASE_BITS = 24;
   localparam logic signed [27:0] TURN_Q = 28'sd360 <<< FRAC_BITS;

   // Phase = floor(r * 2^24 / (45 * 2^19)) = floor((r << PH_SHIFT) / 45)
   localparam int PH_SHIFT = PHASE_BITS - FRAC_BITS - 3;
   localparam int PH_RCP_K = 36;
   localparam logic [63:0] PH_RCP = ((64'd1 << PH_RCP_K) + 64'd44) / 64'd45;

   localparam logic [31:0] PI_Q30  = 32'd3373259426;
   localparam logic [30:0] ONE_Q30 = 31'd1 << 30;

   // Reciprocals of the Taylor factorial steps: n / d == (n * rcp) >> shf for n < 2^30
   localparam logic [63:0] SIN_RCP [4] = '{
      ((64'd1 << 33) + 64'd5) / 64'd6,
      ((64'd1 << 35) + 64'd19) / 64'd20,
      ((64'd1 << 36) + 64'd41) / 64'd42,
      ((64'd1 << 37) + 64'd71) / 64'd72};
   localparam int SIN_SHF [4] = '{33, 35, 36, 37};
   localparam logic [63:0] COS_RCP [4] = '{
      ((64'd1 << 31) + 64'd1) / 64'd2,
      ((64'd1 << 34) + 64'd11) / 64'd12,
      ((64'd1 << 35) + 64'd29) / 64'd30,
      ((64'd1 << 36) + 64'd55) / 64'd56};
   localparam int COS_SHF [4] = '{31, 34, 35, 36};

   localparam int SER_STAGES = 8;
   localparam int PIPE_LAT   = 18;
   localparam int POS_DLY    = PIPE_LAT - 1;

   // Register indexes and reset values
   localparam logic [1:0] REG_OFFSET_X = 2'd0;
   localparam logic [1:0] REG_OFFSET_Y = 2'd1;
   localparam logic [1:0] REG_OFFSET_Z = 2'd2;
   localparam logic signed [31:0] OFFSET_X_RST = 32'sd70 <<< FRAC_BITS;
   localparam logic signed [31:0] OFFSET_Y_RST = 32'sd0;
   localparam logic signed [31:0] OFFSET_Z_RST = 32'sd150 <<< FRAC_BITS;

   // Sine/cosine series state of one angle lane
   typedef struct packed {
      logic [29:0] x2;
      logic [30:0] st;
      logic [30:0] ct;
      logic [30:0] s;
      logic [30:0] c;
      logic [1:0]  quad;
      logic        comp;
   } series_type;

   // Divide by 2^30, rounding the magnitude half away from zero
   function automatic logic signed [37:0] round_shift30(input logic signed [67:0] v);
      logic [67:0] mag;
      logic [37:0] q;
      mag = v[67] ? 68'(-v) : 68'(v);
      mag = mag + (68'd1 << 29);
      q   = mag[67:30];
      return v[67] ? 38'(-$signed(q)) : $signed(q);
   endfunction

   // Q30 product with rounding
   function automatic logic signed [31:0] mul30(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
      logic signed [67:0] p;
      p = 68'(a) * 68'(b);
      return 32'(round_shift30(p));
   endfunction

endpackage

// ----- hdl/pose_tool_offset_transform.sv -----
// Pipelined tool-point transform: flange pose plus rotated tool offset.
//
//  channel   direction  ports                               handshake
//  request   in         req_pos_*, req_angle_*              start / busy
//  response  out        rsp_tool_*                          rsp_valid strobe
//  csr       in         csr_index, csr_wdata                csr_we
//
// One word enters per cycle; results leave in the order of their requests.
// Stages: reduction, phase, radians, square, four multiply and four
// reciprocal-divide stages per angle, signs, three matrix, two sum stages.
// busy stays low; the pipeline never stalls and the receiver cannot hold off.
// Synchronous reset clears the valid bits and loads the default offsets.
`timescale 1ns / 1ps
module pose_tool_offset_transform (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [25:0] req_angle_x,
   input  logic signed [25:0] req_angle_y,
   input  logic signed [25:0] req_angle_z,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_tool_x,
   output logic signed [31:0] rsp_tool_y,
   output logic signed [31:0] rsp_tool_z,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import ptot_pkg::*;

   logic signed [31:0] off_ff [3];
   logic signed [31:0] off_in [3];
   logic [PIPE_LAT-1:0] vld_ff, vld_in;
   logic signed [31:0] pos_ff [POS_DLY][3];
   logic signed [31:0] pos_in [POS_DLY][3];
   logic [24:0]        red_ff [3], red_in [3];
   logic [23:0]        phase_ff [3], phase_in [3];
   logic [29:0]        x_ff [3], x_in [3];
   logic [1:0]         quad_ff [3], quad_in [3];
   logic               comp_ff [3], comp_in [3];
   series_type         ser_ff [SER_STAGES+1][3];
   series_type         ser_in [SER_STAGES+1][3];
   logic signed [31:0] sin_ff [3], sin_in [3];
   logic signed [31:0] cos_ff [3], cos_in [3];
   logic signed [31:0] m1_ff [13], m1_in [13];
   logic signed [32:0] rot_ff [9], rot_in [9];
   logic signed [65:0] prd_ff [9], prd_in [9];
   logic signed [65:0] acc_ff [3], acc_in [3];
   logic signed [31:0] out_ff [3], out_in [3];

   // Write offset registers; ignore unknown indexes
   always_comb begin
      off_in = off_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_OFFSET_X: off_in[0] = csr_wdata;
            REG_OFFSET_Y: off_in[1] = csr_wdata;
            REG_OFFSET_Z: off_in[2] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff[0] <= OFFSET_X_RST;
         off_ff[1] <= OFFSET_Y_RST;
         off_ff[2] <= OFFSET_Z_RST;
         vld_ff    <= '0;
      end else begin
         off_ff <= off_in;
         vld_ff <= vld_in;
      end
   end

   // Advance valid bits and carry the position alongside
   assign vld_in = {vld_ff[PIPE_LAT-2:0], start};
   always_comb begin
      pos_in[0][0] = req_pos_x;
      pos_in[0][1] = req_pos_y;
      pos_in[0][2] = req_pos_z;
      for (int i = 1; i < POS_DLY; i++) begin
         pos_in[i] = pos_ff[i-1];
      end
   end

   // Reduce angles to one turn, then scale to phase
   always_comb begin
      logic signed [27:0] a;
      logic signed [27:0] r;
      logic [63:0]        pp;
      for (int j = 0; j < 3; j++) begin
         case (j)
            0:       a = 28'(req_angle_x);
            1:       a = 28'(req_angle_y);
            default: a = 28'(req_angle_z);
         endcase
         if (a >= TURN_Q)         r = a - TURN_Q;
         else if (!a[27])         r = a;
         else if (a >= -TURN_Q)   r = a + TURN_Q;
         else                     r = a + (TURN_Q <<< 1);
         red_in[j] = r[24:0];
         pp = 64'({red_ff[j], PH_SHIFT'(0)}) * PH_RCP;
         phase_in[j] = 24'(pp >> PH_RCP_K);
      end
   end

   // Fold to one octant and convert to radians
   always_comb begin
      logic [21:0] f;
      logic [22:0] g;
      logic [63:0] xp;
      for (int j = 0; j < 3; j++) begin
         f = phase_ff[j][21:0];
         comp_in[j] = f[21];
         quad_in[j] = phase_ff[j][23:22];
         g = f[21] ? (23'd1 << 22) - 23'(f) : 23'(f);
         xp = 64'(g) * 64'(PI_Q30);
         x_in[j] = 30'(xp >> (PHASE_BITS - 1));
      end
   end

   // Run the Taylor series: multiply stage, then divide-and-accumulate stage
   always_comb begin
      logic [63:0] sq;
      logic [63:0] ps;
      logic [63:0] pc;
      series_type  pv;
      series_type  nx;
      int          kk;
      for (int j = 0; j < 3; j++) begin
         sq = 64'(x_ff[j]) * 64'(x_ff[j]);
         nx.x2   = 30'(sq >> 30);
         nx.st   = 31'(x_ff[j]);
         nx.s    = 31'(x_ff[j]);
         nx.ct   = ONE_Q30;
         nx.c    = ONE_Q30;
         nx.quad = quad_ff[j];
         nx.comp = comp_ff[j];
         ser_in[0][j] = nx;
      end
      for (int i = 1; i <= SER_STAGES; i++) begin
         for (int j = 0; j < 3; j++) begin
            pv = ser_ff[i-1][j];
            nx = pv;
            kk = (i >> 1) - 1;
            if (i % 2 == 1) begin
               ps = 64'(pv.st) * 64'(pv.x2);
               pc = 64'(pv.ct) * 64'(pv.x2);
               nx.st = 31'(ps >> 30);
               nx.ct = 31'(pc >> 30);
            end else begin
               ps = 64'(pv.st) * SIN_RCP[kk];
               pc = 64'(pv.ct) * COS_RCP[kk];
               nx.st = 31'(ps >> SIN_SHF[kk]);
               nx.ct = 31'(pc >> COS_SHF[kk]);
               if (kk % 2 == 0) begin
                  nx.s = pv.s - nx.st;
                  nx.c = pv.c - nx.ct;
               end else begin
                  nx.s = pv.s + nx.st;
                  nx.c = pv.c + nx.ct;
               end
            end
            ser_in[i][j] = nx;
         end
      end
   end

   // Apply octant swap and quadrant signs
   always_comb begin
      logic signed [31:0] so;
      logic signed [31:0] co;
      series_type         sv;
      for (int j = 0; j < 3; j++) begin
         sv = ser_ff[SER_STAGES][j];
         so = sv.comp ? $signed(32'(sv.c)) : $signed(32'(sv.s));
         co = sv.comp ? $signed(32'(sv.s)) : $signed(32'(sv.c));
         case (sv.quad)
            2'd0:    begin sin_in[j] = so;  cos_in[j] = co;  end
            2'd1:    begin sin_in[j] = co;  cos_in[j] = -so; end
            2'd2:    begin sin_in[j] = -so; cos_in[j] = -co; end
            default: begin sin_in[j] = -co; cos_in[j] = so;  end
         endcase
      end
   end

   // Form pairwise products, then rotation matrix entries
   always_comb begin
      m1_in[0]  = mul30(sin_ff[0], sin_ff[1]);  // sx*sy
      m1_in[1]  = mul30(cos_ff[0], sin_ff[1]);  // cx*sy
      m1_in[2]  = mul30(cos_ff[1], cos_ff[2]);  // cy*cz
      m1_in[3]  = mul30(cos_ff[1], sin_ff[2]);  // cy*sz
      m1_in[4]  = mul30(cos_ff[0], sin_ff[2]);  // cx*sz
      m1_in[5]  = mul30(cos_ff[0], cos_ff[2]);  // cx*cz
      m1_in[6]  = mul30(sin_ff[0], cos_ff[1]);  // sx*cy
      m1_in[7]  = mul30(sin_ff[0], sin_ff[2]);  // sx*sz
      m1_in[8]  = mul30(sin_ff[0], cos_ff[2]);  // sx*cz
      m1_in[9]  = mul30(cos_ff[0], cos_ff[1]);  // cx*cy
      m1_in[10] = sin_ff[1];
      m1_in[11] = sin_ff[2];
      m1_in[12] = cos_ff[2];

      rot_in[0] = 33'(m1_ff[2]);
      rot_in[1] = -33'(m1_ff[3]);
      rot_in[2] = 33'(m1_ff[10]);
      rot_in[3] = 33'(m1_ff[4]) + 33'(mul30(m1_ff[0], m1_ff[12]));
      rot_in[4] = 33'(m1_ff[5]) - 33'(mul30(m1_ff[0], m1_ff[11]));
      rot_in[5] = -33'(m1_ff[6]);
      rot_in[6] = 33'(m1_ff[7]) - 33'(mul30(m1_ff[1], m1_ff[12]));
      rot_in[7] = 33'(m1_ff[8]) + 33'(mul30(m1_ff[1], m1_ff[11]));
      rot_in[8] = 33'(m1_ff[9]);
   end

   // Multiply by offsets, sum rows, add position and saturate
   always_comb begin
      logic signed [37:0] rs;
      logic signed [38:0] t;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prd_in[r*3+c] = 66'(rot_ff[r*3+c]) * 66'(off_ff[c]);
         end
         acc_in[r] = prd_ff[r*3] + prd_ff[r*3+1] + prd_ff[r*3+2];
         rs = round_shift30(68'(acc_ff[r]));
         t  = 39'(rs) + 39'(pos_ff[POS_DLY-1][r]);
         if (t > 39'sd2147483647)       out_in[r] = 32'sh7fffffff;
         else if (t < -39'sd2147483648) out_in[r] = 32'sh80000000;
         else                           out_in[r] = 32'(t);
      end
   end

   // Hold payload pipeline registers
   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      red_ff   <= red_in;
      phase_ff <= phase_in;
      x_ff     <= x_in;
      quad_ff  <= quad_in;
      comp_ff  <= comp_in;
      ser_ff   <= ser_in;
      sin_ff   <= sin_in;
      cos_ff   <= cos_in;
      m1_ff    <= m1_in;
      rot_ff   <= rot_in;
      prd_ff   <= prd_in;
      acc_ff   <= acc_in;
      out_ff   <= out_in;
   end

   assign busy       = 1'b0;
   assign rsp_valid  = vld_ff[PIPE_LAT-1];
   assign rsp_tool_x = out_ff[0];
   assign rsp_tool_y = out_ff[1];
   assign rsp_tool_z = out_ff[2];

   // Every accepted word yields a response after the fixed latency
   a_latency_fwd: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_LAT rsp_valid)
      else $error("accepted word produced no response");

   // No response without a matching request
   a_latency_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, PIPE_LAT))
      else $error("response without request");

endmodule

// ----- test/pose_tool_offset_transform_tb.sv -----
// Self-checking testbench for the pose tool offset transform.
`timescale 1ns / 1ps
module pose_tool_offset_transform_tb;
   import ptot_pkg::*;

   localparam int ITEMS       = 2000;
   localparam int CALM_ITEMS  = 300;
   localparam int DRAIN_WAIT  = PIPE_LAT + 6;
   localparam int STALL_LIMIT = 4000;
   localparam longint ANG_MAX = 64'sd23592960;

   typedef struct {
      int x;
      int y;
      int z;
   } tool_point_type;

   // Tool-point predictor and queue of expected words
   class tool_point_board;
      longint ofs_x, ofs_y, ofs_z;
      tool_point_type pending[$];
      int errors;

      function new();
         ofs_x = OFFSET_X_RST;
         ofs_y = OFFSET_Y_RST;
         ofs_z = OFFSET_Z_RST;
         errors = 0;
      endfunction

      function void set_offset(logic [1:0] idx, logic [31:0] val);
         case (idx)
            REG_OFFSET_X: ofs_x = longint'($signed(val));
            REG_OFFSET_Y: ofs_y = longint'($signed(val));
            REG_OFFSET_Z: ofs_z = longint'($signed(val));
            default: ;
         endcase
      endfunction

      // Divide by 2^30, magnitude rounded half away from zero
      function longint round30(longint v);
         bit [63:0] mag;
         mag = (v < 0) ? 64'(-v) : 64'(v);
         mag = (mag + (64'd1 << 29)) >> 30;
         return (v < 0) ? -longint'(mag) : longint'(mag);
      endfunction

      function longint qmul(longint a, longint b);
         return round30(a * b);
      endfunction

      // Phase, quadrant fold, then Taylor series in Q30
      function void sin_cos(longint ang, output longint s_o, output longint c_o);
         longint turn;
         longint r;
         bit [63:0] ph, f, g, x, x2, st, s, ct, c;
         longint so, co;
         bit [1:0] quad;
         bit comp;
         turn = longint'(360) << FRAC_BITS;
         r = ang % turn;
         if (r < 0) r += turn;
         ph = (64'(r) << PHASE_BITS) / 64'(turn);
         quad = ph[PHASE_BITS-1 -: 2];
         f = ph & ((64'd1 << (PHASE_BITS - 2)) - 1);
         comp = f >= (64'd1 << (PHASE_BITS - 3));
         g = comp ? (64'd1 << (PHASE_BITS - 2)) - f : f;
         x = (g * 64'(PI_Q30)) >> (PHASE_BITS - 1);
         x2 = (x * x) >> 30;
         st = x;
         s = x;
         ct = 64'd1 << 30;
         c = ct;
         for (int k = 1; k <= 4; k++) begin
            st = ((st * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            ct = ((ct * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
            if (k % 2 == 1) begin
               s = s - st;
               c = c - ct;
            end else begin
               s = s + st;
               c = c + ct;
            end
         end
         so = comp ? longint'(c) : longint'(s);
         co = comp ? longint'(s) : longint'(c);
         case (quad)
            2'd0: begin s_o = so;  c_o = co;  end
            2'd1: begin s_o = co;  c_o = -so; end
            2'd2: begin s_o = -so; c_o = -co; end
            default: begin s_o = -co; c_o = so; end
         endcase
      endfunction

      function int row(longint p, longint r0, longint r1, longint r2);
         longint v;
         v = p + round30(r0 * ofs_x + r1 * ofs_y + r2 * ofs_z);
         if (v > 64'sd2147483647) v = 64'sd2147483647;
         if (v < -64'sd2147483648) v = -64'sd2147483648;
         return int'(v);
      endfunction

      // Note an accepted pose: push its tool point
      function void note_pose(int px, int py, int pz,
                              logic signed [25:0] ax, logic signed [25:0] ay,
                              logic signed [25:0] az);
         longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
         tool_point_type t;
         sin_cos(longint'(ax), sx, cx);
         sin_cos(longint'(ay), sy, cy);
         sin_cos(longint'(az), sz, cz);
         sxsy = qmul(sx, sy);
         cxsy = qmul(cx, sy);
         t.x = row(px, qmul(cy, cz), -qmul(cy, sz), sy);
         t.y = row(py, qmul(cx, sz) + qmul(sxsy, cz), qmul(cx, cz) - qmul(sxsy, sz),
                   -qmul(sx, cy));
         t.z = row(pz, qmul(sx, sz) - qmul(cxsy, cz), qmul(sx, cz) + qmul(cxsy, sz),
                   qmul(cx, cy));
         pending.push_back(t);
      endfunction

      task report(string msg);
         $display("MISMATCH @%0t: %s", $time, msg);
         errors++;
      endtask

      // Check one result word against the oldest expectation
      task check_word(int tx, int ty, int tz);
         tool_point_type e;
         if (pending.size() == 0) begin
            report($sformatf("unexpected word %0d %0d %0d", tx, ty, tz));
         end else begin
            e = pending.pop_front();
            if (tx != e.x) report($sformatf("tool_x got %0d want %0d", tx, e.x));
            if (ty != e.y) report($sformatf("tool_y got %0d want %0d", ty, e.y));
            if (tz != e.z) report($sformatf("tool_z got %0d want %0d", tz, e.z));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [31:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic signed [25:0] req_angle_x = '0, req_angle_y = '0, req_angle_z = '0;
   logic rsp_valid;
   logic signed [31:0] rsp_tool_x, rsp_tool_y, rsp_tool_z;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   tool_point_board board = new();
   int stall_cycles = 0;
   bit calm = 1'b0;

   pose_tool_offset_transform i_dut (.*);

   always #1 clock = ~clock;

   // Sample both channels; count cycles with no progress
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            board.note_pose(req_pos_x, req_pos_y, req_pos_z,
                            req_angle_x, req_angle_y, req_angle_z);
         if (rsp_valid)
            board.check_word(rsp_tool_x, rsp_tool_y, rsp_tool_z);
         if ((start && !busy) || rsp_valid)
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
      end
   end

   // Watchdog
   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("pose_tool_offset_transform_tb: done, errors");
      $finish;
   end

   // Drive one pose and hold it until accepted, with an optional gap first
   task send_pose(int px, int py, int pz, int ax, int ay, int az);
      if (!calm && $urandom_range(0, 5) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      start <= 1'b1;
      req_pos_x <= px;
      req_pos_y <= py;
      req_pos_z <= pz;
      req_angle_x <= 26'(ax);
      req_angle_y <= 26'(ay);
      req_angle_z <= 26'(az);
      do @(posedge clock); while (busy);
   endtask

   // Hold off until every expected word is back and the pipe is empty
   task drain();
      start <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task write_offsets(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz);
      logic [31:0] vals[3];
      logic [1:0] idx[3];
      vals = '{ox, oy, oz};
      idx = '{REG_OFFSET_X, REG_OFFSET_Y, REG_OFFSET_Z};
      for (int i = 0; i < 3; i++) begin
         csr_we <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         board.set_offset(idx[i], vals[i]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   function int rand_angle();
      if ($urandom_range(0, 9) < 8)
         return int'($urandom_range(0, 2 * ANG_MAX)) - int'(ANG_MAX);
      return int'($signed(26'($urandom)));
   endfunction

   function int rand_pos();
      if ($urandom_range(0, 3) == 0)
         return int'($urandom);
      return int'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000;
   endfunction

   task random_poses(int n);
      for (int i = 0; i < n; i++)
         send_pose(rand_pos(), rand_pos(), rand_pos(),
                   rand_angle(), rand_angle(), rand_angle());
   endtask

   initial begin
      int d;
      int angs[14];
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: quadrant edges, the 45 degree fold, wrap beyond one turn
      d = 1 << FRAC_BITS;
      angs = '{0, 45 * d, -45 * d, 90 * d, -90 * d, 180 * d, -180 * d, 270 * d,
               360 * d, -360 * d, 30 * d + 1, -(1 << 25), (1 << 25) - 1, 1};
      for (int i = 0; i < 14; i++)
         send_pose(i * d, -i * d, 7 * d, angs[i], angs[(i + 3) % 14], angs[(i + 7) % 14]);
      // Saturation at both ends of the position range
      send_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0);
      send_pose(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 180 * d, 0, 0);
      send_pose(32'h8000_0000, 32'h7FFF_FFFF, 0, 90 * d, 90 * d, 90 * d);
      drain();

      // Offset extremes, then random offsets, then back to defaults
      write_offsets(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
      send_pose(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0);
      send_pose(32'h8000_0000, 32'h7FFF_FFFF, 0, 180 * d, 0, 90 * d);
      random_poses(400);
      drain();
      write_offsets(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      random_poses(400);
      drain();
      write_offsets($urandom, $urandom, $urandom);
      random_poses(400);
      drain();
      write_offsets(OFFSET_X_RST, OFFSET_Y_RST, OFFSET_Z_RST);
      random_poses(ITEMS - 1200 - CALM_ITEMS);
      calm = 1'b1;
      random_poses(CALM_ITEMS);
      drain();

      if (board.errors == 0)
         $display("pose_tool_offset_transform_tb: done, clean");
      else
         $display("pose_tool_offset_transform_tb: done, errors");
      $finish;
   end
endmodule

// ----- files.f -----
hdl/ptot_pkg.sv
hdl/pose_tool_offset_transform.sv
test/pose_tool_offset_transform_tb.sv
